>>> rtl/dstt_pkg.sv
// ----------------------------------------------------------------------------
// dstt_pkg: shared types and constants for the deadline sorted timer table
// command word layout, command classes and parameter defaults
// ----------------------------------------------------------------------------
package dstt_pkg;

  localparam int DEF_NUM_TIMERS = 16;
  localparam int DEF_TICK_BITS  = 32;

  localparam int ID_W        = 4;
  localparam int TIMEOUT_W   = 16;
  localparam int STAMP_W     = 16;
  localparam int ADDRESSABLE = 2 ** ID_W;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // command class decided at the front
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ARM    = 2'd1,
    OP_CANCEL = 2'd2
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [ID_W-1:0]      id;
    logic [TIMEOUT_W-1:0] timeout;
  } cmd_t;

endpackage

>>> rtl/deadline_sorted_timer_table_core.sv
// ----------------------------------------------------------------------------
// deadline_sorted_timer_table_core: one-shot timer table over a tick count
// reset commands arm or cancel timers, tick commands emit expiries in order
// ----------------------------------------------------------------------------
// Every word that is not dropped passes through a two-word queue before the
// engine sees it. A reset command (tuser high) is then taken while the engine
// is idle. On a tick the engine walks the table of addressable timers
// (min(NUM_TIMERS, 16)) one entry a cycle, once for each expiry it emits and
// once when nothing expires, and each expiry waits on top of that for as long
// as the output register still holds an earlier word that has not been taken.
// The queue lets new commands be taken while the engine works. Expiries come
// out most overdue first, most recently armed first on equal deadlines, with
// tlast on the final one of the tick.
module deadline_sorted_timer_table_core #(
  parameter int NUM_TIMERS = dstt_pkg::DEF_NUM_TIMERS,
  parameter int TICK_BITS  = dstt_pkg::DEF_TICK_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dstt_pkg::IN_DATA_W-1:0]  s_tdata,   // timer_id[3:0], timeout[19:4]
  input  logic                            s_tuser,   // command
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dstt_pkg::OUT_DATA_W-1:0] m_tdata,   // expired_timer[3:0]
  output logic                            m_tlast
);

  logic                      cmd_valid;
  logic                      cmd_ready;
  dstt_pkg::cmd_t            cmd;
  logic [dstt_pkg::ID_W-1:0] out_id;

  dstt_front #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dstt_back #(
    .NUM_TIMERS (NUM_TIMERS),
    .TICK_BITS  (TICK_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_id    (out_id),
    .out_last  (m_tlast)
  );

  assign m_tdata = dstt_pkg::OUT_DATA_W'(out_id);

endmodule

>>> rtl/dstt_front.sv
// ----------------------------------------------------------------------------
// dstt_front: command intake
// accepts input words, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module dstt_front #(
  parameter int NUM_TIMERS = dstt_pkg::DEF_NUM_TIMERS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dstt_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output dstt_pkg::cmd_t                 cmd
);

  localparam int LIMIT = (NUM_TIMERS < dstt_pkg::ADDRESSABLE) ?
                         NUM_TIMERS : dstt_pkg::ADDRESSABLE;
  localparam int LIM_W = dstt_pkg::ID_W + 1;

  logic [dstt_pkg::ID_W-1:0]      in_id;
  logic [dstt_pkg::TIMEOUT_W-1:0] in_timeout;
  logic                           in_ignore;
  dstt_pkg::cmd_t                 in_cmd;

  dstt_pkg::cmd_t q_mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign in_id      = s_tdata[dstt_pkg::ID_W-1:0];
  assign in_timeout = s_tdata[dstt_pkg::ID_W +: dstt_pkg::TIMEOUT_W];

  // a reset aimed past the table has no effect and is dropped here
  always_comb begin
    in_ignore      = 1'b0;
    in_cmd.id      = in_id;
    in_cmd.timeout = in_timeout;
    if (!s_tuser) begin
      in_cmd.op = dstt_pkg::OP_TICK;
    end else if (in_timeout == '0) begin
      in_cmd.op = dstt_pkg::OP_CANCEL;
    end else begin
      in_cmd.op = dstt_pkg::OP_ARM;
    end
    if (s_tuser && ({1'b0, in_id} >= LIM_W'(LIMIT))) begin
      in_ignore = 1'b1;
    end
  end

  assign s_tready  = (count != 2'd2);
  assign push      = s_tvalid && s_tready && !in_ignore;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_cmd;
    end
  end

endmodule

>>> rtl/dstt_back.sv
// ----------------------------------------------------------------------------
// dstt_back: timer table engine
// applies arm and cancel commands; on a tick scans the table once per expiry
// (once if none is due) to pick the most overdue timer for the output register
// ----------------------------------------------------------------------------
module dstt_back #(
  parameter int NUM_TIMERS = dstt_pkg::DEF_NUM_TIMERS,
  parameter int TICK_BITS  = dstt_pkg::DEF_TICK_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  dstt_pkg::cmd_t            cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dstt_pkg::ID_W-1:0] out_id,
  output logic                      out_last
);

  localparam int LIMIT = (NUM_TIMERS < dstt_pkg::ADDRESSABLE) ?
                         NUM_TIMERS : dstt_pkg::ADDRESSABLE;
  localparam int IDX_W = $clog2(LIMIT);
  localparam int SUM_W = (TICK_BITS > dstt_pkg::TIMEOUT_W) ?
                         TICK_BITS : dstt_pkg::TIMEOUT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;

  logic [TICK_BITS-1:0]        now;
  logic [dstt_pkg::STAMP_W-1:0] stamp_cnt;
  logic [LIMIT-1:0]            armed;
  logic [LIMIT-1:0]            due;
  logic [TICK_BITS-1:0]        deadline [LIMIT];
  logic [dstt_pkg::STAMP_W-1:0] set_stamp [LIMIT];

  logic [IDX_W-1:0]            scan_idx;
  logic                        first;
  logic                        found;
  logic [IDX_W-1:0]            best_idx;
  logic [TICK_BITS-1:0]        best_ovd;
  logic [dstt_pkg::STAMP_W-1:0] best_age;

  logic [IDX_W-1:0]            cmd_idx;
  logic [SUM_W-1:0]            arm_sum;
  logic [TICK_BITS-1:0]        ovd;
  logic [dstt_pkg::STAMP_W-1:0] age;
  logic                        reached;
  logic                        cand;
  logic                        better;
  logic [LIMIT-1:0]            rest;
  logic                        out_free;
  logic                        arm_wr;
  logic                        emit;

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_idx   = cmd.id[IDX_W-1:0];
  assign arm_sum   = SUM_W'(now) + SUM_W'(cmd.timeout);
  assign arm_wr    = cmd_valid && cmd_ready && (cmd.op == dstt_pkg::OP_ARM);

  // one entry per cycle: wrapped lateness and recency against the running best
  assign ovd     = now - deadline[scan_idx];
  assign age     = stamp_cnt - set_stamp[scan_idx];
  assign reached = armed[scan_idx] && !ovd[TICK_BITS-1];
  assign cand    = first ? reached : due[scan_idx];
  assign better  = !found || (ovd > best_ovd) ||
                   ((ovd == best_ovd) && (age < best_age));

  // timers still due once the chosen one is gone
  always_comb begin
    rest           = due;
    rest[best_idx] = 1'b0;
  end

  assign out_free = !out_valid || out_ready;
  assign emit     = (state == ST_EMIT) && found && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      now       <= '0;
      stamp_cnt <= '0;
      armed     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              dstt_pkg::OP_ARM: begin
                armed[cmd_idx] <= 1'b1;
                stamp_cnt      <= stamp_cnt + dstt_pkg::STAMP_W'(1);
              end
              dstt_pkg::OP_CANCEL: begin
                armed[cmd_idx] <= 1'b0;
              end
              dstt_pkg::OP_TICK: begin
                now      <= now + TICK_BITS'(1);
                scan_idx <= '0;
                first    <= 1'b1;
                found    <= 1'b0;
                state    <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (first) begin
            due[scan_idx] <= reached;
          end
          // ties with an earlier index keep the earlier one
          if (cand && better) begin
            found    <= 1'b1;
            best_idx <= scan_idx;
            best_ovd <= ovd;
            best_age <= age;
          end
          if (scan_idx == IDX_W'(LIMIT - 1)) begin
            state <= ST_EMIT;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        ST_EMIT: begin
          if (!found) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_id          <= dstt_pkg::ID_W'(best_idx);
            out_last        <= (rest == '0);
            due[best_idx]   <= 1'b0;
            armed[best_idx] <= 1'b0;
            if (rest == '0) begin
              state <= ST_IDLE;
            end else begin
              scan_idx <= '0;
              first    <= 1'b0;
              found    <= 1'b0;
              state    <= ST_SCAN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (arm_wr) begin
      deadline[cmd_idx]  <= arm_sum[TICK_BITS-1:0];
      set_stamp[cmd_idx] <= stamp_cnt;
    end
  end

endmodule

>>> rtl/dstt_checker.sv
// ----------------------------------------------------------------------------
// dstt_checker: port-level checks for the timer table
// watches the output stream of the top level
// ----------------------------------------------------------------------------
module dstt_checker #(
  parameter int NUM_TIMERS = dstt_pkg::DEF_NUM_TIMERS
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [dstt_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tlast
);

  localparam int LIMIT = (NUM_TIMERS < dstt_pkg::ADDRESSABLE) ?
                         NUM_TIMERS : dstt_pkg::ADDRESSABLE;
  localparam int IDX_W = $clog2(LIMIT);

  // timers already emitted in the current tick
  logic [LIMIT-1:0] seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (m_tvalid && m_tready) begin
      seen <= m_tlast ? '0 : (seen | (LIMIT'(1) << m_tdata[IDX_W-1:0]));
    end
  end

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // only addressable timers can expire
  a_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata < dstt_pkg::OUT_DATA_W'(LIMIT)))
    else $error("expired timer index out of range");

  // one timer cannot expire twice within a tick
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !seen[m_tdata[IDX_W-1:0]])
    else $error("timer emitted twice in one tick");

endmodule

bind deadline_sorted_timer_table_core dstt_checker #(
  .NUM_TIMERS (NUM_TIMERS)
) u_dstt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
